FILE: src/lfct_pkg.sv
// ----------------------------------------------------------------------------
// lfct_pkg
// Shared types, widths and constants of the point crop and transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfct_pkg;

   // field widths
   localparam int PT_W    = 24;
   localparam int WORLD_W = 32;
   localparam int R2_W    = 48;
   localparam int ROW_W   = 48;
   localparam int BND_W   = 16;
   localparam int CD_W    = 28;
   localparam int ACC_W   = 18;
   localparam int PROD_W  = 40;
   localparam int IDX_W   = 4;
   localparam int DATA_W  = 64;

   // square root steps: one result bit per cell
   localparam int SQ_STEPS = 24;
   localparam int SQ_TOP   = 2 * SQ_STEPS - 2;

   // pi in Q3.13 radians
   localparam logic signed [ACC_W-1:0] ANGLE_PI = 18'sd25736;

   // register indexes
   localparam logic [IDX_W-1:0] REG_ROW0  = 4'd0;
   localparam logic [IDX_W-1:0] REG_ROW1  = 4'd1;
   localparam logic [IDX_W-1:0] REG_ROW2  = 4'd2;
   localparam logic [IDX_W-1:0] REG_OFF_X = 4'd3;
   localparam logic [IDX_W-1:0] REG_OFF_Y = 4'd4;
   localparam logic [IDX_W-1:0] REG_OFF_Z = 4'd5;
   localparam logic [IDX_W-1:0] REG_RANGE = 4'd6;
   localparam logic [IDX_W-1:0] REG_FOV   = 4'd7;

   // transform and range settings seen by the front end
   typedef struct packed {
      logic [ROW_W-1:0]          row0;
      logic [ROW_W-1:0]          row1;
      logic [ROW_W-1:0]          row2;
      logic signed [WORLD_W-1:0] off_x;
      logic signed [WORLD_W-1:0] off_y;
      logic signed [WORLD_W-1:0] off_z;
      logic [R2_W-1:0]           max_range_sq;
   } xform_cfg_type;

   // one point as it travels down the cell chain
   typedef struct packed {
      logic                      valid;
      logic                      cloud_end;
      logic                      range_ok;
      logic                      zero_pt;
      logic                      az_zero;
      logic signed [WORLD_W-1:0] wx;
      logic signed [WORLD_W-1:0] wy;
      logic signed [WORLD_W-1:0] wz;
      logic signed [PT_W-1:0]    pz;
      logic [R2_W-1:0]           rem;
      logic [R2_W-1:0]           res;
      logic signed [CD_W-1:0]    ax;
      logic signed [CD_W-1:0]    ay;
      logic signed [ACC_W-1:0]   aa;
      logic signed [CD_W-1:0]    ex;
      logic signed [CD_W-1:0]    ey;
      logic signed [ACC_W-1:0]   ea;
   } lane_type;

   // rounded Q3.13 arctangent of 2^-i
   function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned i);
      logic signed [ACC_W-1:0] v;
      unique case (i)
         0:       v = 18'sd6434;
         1:       v = 18'sd3798;
         2:       v = 18'sd2007;
         3:       v = 18'sd1019;
         4:       v = 18'sd511;
         5:       v = 18'sd256;
         6:       v = 18'sd128;
         7:       v = 18'sd64;
         8:       v = 18'sd32;
         9:       v = 18'sd16;
         10:      v = 18'sd8;
         11:      v = 18'sd4;
         12:      v = 18'sd2;
         13:      v = 18'sd1;
         default: v = 18'sd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: src/lfct_if.sv
// ----------------------------------------------------------------------------
// lfct_if
// Point, result and register write channels of the crop and transform block.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfct_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [lfct_pkg::PT_W-1:0] point_x;
   logic signed [lfct_pkg::PT_W-1:0] point_y;
   logic signed [lfct_pkg::PT_W-1:0] point_z;
   logic                            cloud_end;
   modport source (output valid, point_x, point_y, point_z, cloud_end, input ready);
   modport sink   (input valid, point_x, point_y, point_z, cloud_end, output ready);
endinterface

interface lfct_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [lfct_pkg::WORLD_W-1:0] world_x;
   logic signed [lfct_pkg::WORLD_W-1:0] world_y;
   logic signed [lfct_pkg::WORLD_W-1:0] world_z;
   logic                               kept;
   logic                               result_end;
   modport source (output valid, world_x, world_y, world_z, kept, result_end, input ready);
   modport sink   (input valid, world_x, world_y, world_z, kept, result_end, output ready);
endinterface

interface lfct_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lfct_pkg::IDX_W-1:0]        index;
   logic [lfct_pkg::DATA_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/lfct_front.sv
// ----------------------------------------------------------------------------
// lfct_front
// Squares, matrix products, rounding, offset and range test in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lfct_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic                            in_valid,
   input  wire logic signed [lfct_pkg::PT_W-1:0] in_x,
   input  wire logic signed [lfct_pkg::PT_W-1:0] in_y,
   input  wire logic signed [lfct_pkg::PT_W-1:0] in_z,
   input  wire logic                            in_end,
   input  wire lfct_pkg::xform_cfg_type         cfg,
   output lfct_pkg::lane_type                   lane_out
);

   localparam int PW = lfct_pkg::PROD_W;
   localparam int SW = PW + 2;
   localparam int RW = SW - 14;
   localparam int WW = lfct_pkg::WORLD_W;

   // stage 1 registers
   logic                      v1_ff, e1_ff;
   logic signed [lfct_pkg::PT_W-1:0] x1_ff, y1_ff, z1_ff;
   logic [lfct_pkg::R2_W-1:0] sx_ff, sy_ff, sz_ff;
   logic signed [PW-1:0]      prod_ff [3][3];
   logic signed [PW-1:0]      prod_in [3][3];
   logic signed [lfct_pkg::PT_W-1:0] pt [3];
   logic [lfct_pkg::ROW_W-1:0] rows [3];

   // stage 2 registers
   logic                      v2_ff, e2_ff;
   logic signed [lfct_pkg::PT_W-1:0] x2_ff, y2_ff, z2_ff;
   logic [lfct_pkg::R2_W-1:0] r2xy_ff, r2_ff;
   logic signed [RW-1:0]      rnd_ff [3];
   logic signed [RW-1:0]      rnd_in [3];
   logic signed [SW-1:0]      acc [3];

   // stage 3
   lfct_pkg::lane_type        lane_in, lane_ff;
   logic signed [WW:0]        wsum [3];
   logic signed [WW-1:0]      wsat [3];
   logic signed [WW-1:0]      offs [3];

   assign pt[0] = in_x;
   assign pt[1] = in_y;
   assign pt[2] = in_z;
   assign rows[0] = cfg.row0;
   assign rows[1] = cfg.row1;
   assign rows[2] = cfg.row2;
   assign offs[0] = cfg.off_x;
   assign offs[1] = cfg.off_y;
   assign offs[2] = cfg.off_z;

   // multiply each matrix entry by its coordinate
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = PW'($signed(rows[r][16*c +: 16]) * pt[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
      end else if (advance) begin
         v1_ff   <= in_valid;
         e1_ff   <= in_end;
         x1_ff   <= in_x;
         y1_ff   <= in_y;
         z1_ff   <= in_z;
         sx_ff   <= lfct_pkg::R2_W'(in_x * in_x);
         sy_ff   <= lfct_pkg::R2_W'(in_y * in_y);
         sz_ff   <= lfct_pkg::R2_W'(in_z * in_z);
         prod_ff <= prod_in;
      end
   end

   // sum each row and round half up to whole millimetres
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2])
                  + SW'(8192);
         rnd_in[r] = acc[r][SW-1:14];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff   <= 1'b0;
      end else if (advance) begin
         v2_ff   <= v1_ff;
         e2_ff   <= e1_ff;
         x2_ff   <= x1_ff;
         y2_ff   <= y1_ff;
         z2_ff   <= z1_ff;
         r2xy_ff <= sx_ff + sy_ff;
         r2_ff   <= sx_ff + sy_ff + sz_ff;
         rnd_ff  <= rnd_in;
      end
   end

   // add offset, saturate, test range and fold the azimuth vector
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         wsum[r] = (WW+1)'(rnd_ff[r]) + (WW+1)'(offs[r]);
         if (wsum[r] > (WW+1)'(33'sh0_7FFF_FFFF)) begin
            wsat[r] = {1'b0, {(WW-1){1'b1}}};
         end else if (wsum[r] < -(WW+1)'(33'sh0_8000_0000)) begin
            wsat[r] = {1'b1, {(WW-1){1'b0}}};
         end else begin
            wsat[r] = wsum[r][WW-1:0];
         end
      end
      lane_in           = '0;
      lane_in.valid     = v2_ff;
      lane_in.cloud_end = e2_ff;
      lane_in.range_ok  = r2_ff < cfg.max_range_sq;
      lane_in.az_zero   = (x2_ff == '0) && (y2_ff == '0);
      lane_in.zero_pt   = lane_in.az_zero && (z2_ff == '0);
      lane_in.wx        = wsat[0];
      lane_in.wy        = wsat[1];
      lane_in.wz        = wsat[2];
      lane_in.pz        = z2_ff;
      lane_in.rem       = r2xy_ff;
      lane_in.res       = '0;
      if (x2_ff < 0) begin
         lane_in.ax = -lfct_pkg::CD_W'(x2_ff);
         lane_in.ay = -lfct_pkg::CD_W'(y2_ff);
         lane_in.aa = (y2_ff >= 0) ? lfct_pkg::ANGLE_PI : -lfct_pkg::ANGLE_PI;
      end else begin
         lane_in.ax = lfct_pkg::CD_W'(x2_ff);
         lane_in.ay = lfct_pkg::CD_W'(y2_ff);
         lane_in.aa = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) lane_ff <= '0;
      else if (advance) lane_ff <= lane_in;
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

FILE: src/lfct_sqrt_cell.sv
// ----------------------------------------------------------------------------
// lfct_sqrt_cell
// One step of the floor square root of x*x + y*y: decides one result bit.
// ----------------------------------------------------------------------------
`default_nettype none

module lfct_sqrt_cell #(
   parameter int BIT_POS = 46
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire lfct_pkg::lane_type lane_prev,
   output lfct_pkg::lane_type      lane_next
);

   localparam logic [lfct_pkg::R2_W-1:0] BIT = lfct_pkg::R2_W'(1) << BIT_POS;

   lfct_pkg::lane_type lane_in, lane_ff;
   logic [lfct_pkg::R2_W-1:0] trial;

   // subtract the trial square when it fits
   always_comb begin
      lane_in = lane_prev;
      trial   = lane_prev.res + BIT;
      if (lane_prev.rem >= trial) begin
         lane_in.rem = lane_prev.rem - trial;
         lane_in.res = (lane_prev.res >> 1) + BIT;
      end else begin
         lane_in.res = lane_prev.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) lane_ff <= '0;
      else if (advance) lane_ff <= lane_in;
   end

   assign lane_next = lane_ff;

endmodule

`default_nettype wire

FILE: src/lfct_cordic_cell.sv
// ----------------------------------------------------------------------------
// lfct_cordic_cell
// One vectoring rotation for both the azimuth and the elevation vector.
// ----------------------------------------------------------------------------
`default_nettype none

module lfct_cordic_cell #(
   parameter int STAGE = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire lfct_pkg::lane_type lane_prev,
   output lfct_pkg::lane_type      lane_next
);

   localparam logic signed [lfct_pkg::ACC_W-1:0] ATAN = lfct_pkg::atan_entry(STAGE);

   lfct_pkg::lane_type lane_in, lane_ff;

   // rotate toward the x axis and accumulate the angle
   always_comb begin
      lane_in = lane_prev;
      if (lane_prev.ay >= 0) begin
         lane_in.ax = lane_prev.ax + (lane_prev.ay >>> STAGE);
         lane_in.ay = lane_prev.ay - (lane_prev.ax >>> STAGE);
         lane_in.aa = lane_prev.aa + ATAN;
      end else begin
         lane_in.ax = lane_prev.ax - (lane_prev.ay >>> STAGE);
         lane_in.ay = lane_prev.ay + (lane_prev.ax >>> STAGE);
         lane_in.aa = lane_prev.aa - ATAN;
      end
      if (lane_prev.ey >= 0) begin
         lane_in.ex = lane_prev.ex + (lane_prev.ey >>> STAGE);
         lane_in.ey = lane_prev.ey - (lane_prev.ex >>> STAGE);
         lane_in.ea = lane_prev.ea + ATAN;
      end else begin
         lane_in.ex = lane_prev.ex - (lane_prev.ey >>> STAGE);
         lane_in.ey = lane_prev.ey + (lane_prev.ex >>> STAGE);
         lane_in.ea = lane_prev.ea - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) lane_ff <= '0;
      else if (advance) lane_ff <= lane_in;
   end

   assign lane_next = lane_ff;

endmodule

`default_nettype wire

FILE: src/lidar_point_fov_crop_transform.sv
// ----------------------------------------------------------------------------
// lidar_point_fov_crop_transform
// Range and field-of-view crop of lidar points with a rigid pose transform.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one sensor point (x, y, z in mm, cloud end mark). rsp_ch
//   returns one item per point: world x, y, z, a kept flag and the end mark.
//   Rejected points come back with kept low and zero coordinates.
//   csr_ch writes the pose, range limit and angle bounds; it is ready
//   whenever reset is low and must be used only while no point is in flight.
// Pipeline:
//   Three front stages, one square-root cell per result bit, one CORDIC
//   cell per stage and the output register. One point is taken every cycle
//   while the output does not stall.
// Reset:
//   Registers return to the identity pose, a 7 m range and the default
//   bounds; all pipeline slots become empty.
// Stall:
//   When rsp_ch holds a result that is not taken the whole chain freezes
//   and req_ch.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_fov_crop_transform #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lfct_req_if.sink    req_ch,
   lfct_rsp_if.source  rsp_ch,
   lfct_csr_if.sink    csr_ch
);

   localparam int AW = lfct_pkg::ACC_W;
   localparam int BW = lfct_pkg::BND_W;

   // configuration registers
   logic [lfct_pkg::ROW_W-1:0]          row0_ff, row1_ff, row2_ff;
   logic signed [lfct_pkg::WORLD_W-1:0] offx_ff, offy_ff, offz_ff;
   logic [lfct_pkg::R2_W-1:0]           range_ff;
   logic [lfct_pkg::DATA_W-1:0]         fov_ff;
   lfct_pkg::xform_cfg_type             cfg;

   logic advance;
   logic out_valid_ff;
   logic signed [lfct_pkg::WORLD_W-1:0] ox_ff, oy_ff, oz_ff;
   logic kept_ff, end_ff;

   lfct_pkg::lane_type sq_lane [lfct_pkg::SQ_STEPS+1];
   lfct_pkg::lane_type cd_lane [CORDIC_STAGES+1];
   lfct_pkg::lane_type last;

   logic signed [AW-1:0] az, el;
   logic keep;

   assign csr_ch.ready = !reset;

   // take register writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff  <= 48'd16384;
         row1_ff  <= 48'd1073741824;
         row2_ff  <= 48'd70368744177664;
         offx_ff  <= '0;
         offy_ff  <= '0;
         offz_ff  <= '0;
         range_ff <= 48'd49000000;
         fov_ff   <= 64'd170940185705495;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            lfct_pkg::REG_ROW0:  row0_ff  <= csr_ch.data[lfct_pkg::ROW_W-1:0];
            lfct_pkg::REG_ROW1:  row1_ff  <= csr_ch.data[lfct_pkg::ROW_W-1:0];
            lfct_pkg::REG_ROW2:  row2_ff  <= csr_ch.data[lfct_pkg::ROW_W-1:0];
            lfct_pkg::REG_OFF_X: offx_ff  <= csr_ch.data[lfct_pkg::WORLD_W-1:0];
            lfct_pkg::REG_OFF_Y: offy_ff  <= csr_ch.data[lfct_pkg::WORLD_W-1:0];
            lfct_pkg::REG_OFF_Z: offz_ff  <= csr_ch.data[lfct_pkg::WORLD_W-1:0];
            lfct_pkg::REG_RANGE: range_ff <= csr_ch.data[lfct_pkg::R2_W-1:0];
            lfct_pkg::REG_FOV:   fov_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign cfg.row0         = row0_ff;
   assign cfg.row1         = row1_ff;
   assign cfg.row2         = row2_ff;
   assign cfg.off_x        = offx_ff;
   assign cfg.off_y        = offy_ff;
   assign cfg.off_z        = offz_ff;
   assign cfg.max_range_sq = range_ff;

   // advance the whole chain unless the output item is held
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance && !reset;

   lfct_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_ch.valid),
      .in_x     (req_ch.point_x),
      .in_y     (req_ch.point_y),
      .in_z     (req_ch.point_z),
      .in_end   (req_ch.cloud_end),
      .cfg      (cfg),
      .lane_out (sq_lane[0])
   );

   for (genvar k = 0; k < lfct_pkg::SQ_STEPS; k++) begin : g_sqrt
      lfct_sqrt_cell #(
         .BIT_POS (lfct_pkg::SQ_TOP - 2*k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .lane_prev (sq_lane[k]),
         .lane_next (sq_lane[k+1])
      );
   end

   // start the elevation vector from (hypot(x,y), z)
   always_comb begin
      cd_lane[0]    = sq_lane[lfct_pkg::SQ_STEPS];
      cd_lane[0].ex = lfct_pkg::CD_W'(sq_lane[lfct_pkg::SQ_STEPS].res);
      cd_lane[0].ey = lfct_pkg::CD_W'(sq_lane[lfct_pkg::SQ_STEPS].pz);
      cd_lane[0].ea = '0;
   end

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
      lfct_cordic_cell #(
         .STAGE (s)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .lane_prev (cd_lane[s]),
         .lane_next (cd_lane[s+1])
      );
   end

   assign last = cd_lane[CORDIC_STAGES];

   // clamp angles, apply the bounds and zero rejected points
   always_comb begin
      if (last.az_zero) begin
         az = '0;
      end else if (last.aa > lfct_pkg::ANGLE_PI) begin
         az = lfct_pkg::ANGLE_PI;
      end else if (last.aa < -lfct_pkg::ANGLE_PI) begin
         az = -lfct_pkg::ANGLE_PI;
      end else begin
         az = last.aa;
      end
      if (last.zero_pt) begin
         el = '0;
      end else if (last.ea > lfct_pkg::ANGLE_PI) begin
         el = lfct_pkg::ANGLE_PI;
      end else if (last.ea < -lfct_pkg::ANGLE_PI) begin
         el = -lfct_pkg::ANGLE_PI;
      end else begin
         el = last.ea;
      end
      keep = last.range_ok
          && (el >= AW'($signed(fov_ff[BW-1:0])))
          && (el <= AW'($signed(fov_ff[2*BW-1:BW])))
          && (az >= AW'($signed(fov_ff[3*BW-1:2*BW])))
          && (az <= AW'($signed(fov_ff[4*BW-1:3*BW])));
   end

   // hold the result item until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last.valid;
         kept_ff      <= keep;
         end_ff       <= last.cloud_end;
         ox_ff        <= keep ? last.wx : '0;
         oy_ff        <= keep ? last.wy : '0;
         oz_ff        <= keep ? last.wz : '0;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.world_x    = ox_ff;
   assign rsp_ch.world_y    = oy_ff;
   assign rsp_ch.world_z    = oz_ff;
   assign rsp_ch.kept       = kept_ff;
   assign rsp_ch.result_end = end_ff;

endmodule

`default_nettype wire

FILE: verif/tb_lidar_point_fov_crop_transform.sv
// ----------------------------------------------------------------------------
// tb_lidar_point_fov_crop_transform
// Self-checking bench for the lidar point crop and pose transform block.
// The bench drives points and register writes and predicts every result
// from its own fixed-point model. It compares each result with the oldest
// expected item, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

// expected world point of one lidar sample
typedef struct {
   logic signed [31:0] wx;
   logic signed [31:0] wy;
   logic signed [31:0] wz;
   logic               kept;
   logic               last;
} world_pt_type;

class crop_scoreboard;
   logic [47:0] row [3];
   logic signed [31:0] offs [3];
   logic [47:0] range_lim;
   logic [63:0] bounds;
   world_pt_type pending [$];
   int          errors;
   int          n_kept;
   int          n_seen;

   function void set_defaults();
      row[0] = 48'd16384;
      row[1] = 48'd1073741824;
      row[2] = 48'd70368744177664;
      offs[0] = 0;
      offs[1] = 0;
      offs[2] = 0;
      range_lim = 48'd49000000;
      bounds = 64'd170940185705495;
   endfunction

   function void write_reg(logic [3:0] idx, logic [63:0] d);
      case (idx)
         lfct_pkg::REG_ROW0:  row[0] = d[47:0];
         lfct_pkg::REG_ROW1:  row[1] = d[47:0];
         lfct_pkg::REG_ROW2:  row[2] = d[47:0];
         lfct_pkg::REG_OFF_X: offs[0] = d[31:0];
         lfct_pkg::REG_OFF_Y: offs[1] = d[31:0];
         lfct_pkg::REG_OFF_Z: offs[2] = d[31:0];
         lfct_pkg::REG_RANGE: range_lim = d[47:0];
         lfct_pkg::REG_FOV:   bounds = d;
         default: ;
      endcase
   endfunction

   // vectoring arctangent, Q3.13 radians
   function longint angle_of(longint y, longint x);
      longint z, xs, ys;
      longint tbl [14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 25736 : -25736;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z += (i < 14) ? tbl[i] : 0;
         end else begin
            x = x - ys;
            y = y + xs;
            z -= (i < 14) ? tbl[i] : 0;
         end
      end
      if (z > 25736) z = 25736;
      if (z < -25736) z = -25736;
      return z;
   endfunction

   function longint floor_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // predict the result of one accepted point
   function void note_point(logic signed [23:0] px, logic signed [23:0] py,
                            logic signed [23:0] pz, logic ce);
      longint p [3];
      longint r2xy, r2, rxy, az, el, acc;
      logic signed [15:0] e;
      world_pt_type w;
      logic ok;
      p[0] = longint'(px);
      p[1] = longint'(py);
      p[2] = longint'(pz);
      r2xy = p[0] * p[0] + p[1] * p[1];
      r2 = r2xy + p[2] * p[2];
      rxy = floor_sqrt(r2xy);
      az = angle_of(p[1], p[0]);
      el = angle_of(p[2], rxy);
      ok = (r2 < longint'({16'd0, range_lim}))
         && el >= longint'($signed(bounds[15:0]))
         && el <= longint'($signed(bounds[31:16]))
         && az >= longint'($signed(bounds[47:32]))
         && az <= longint'($signed(bounds[63:48]));
      w.kept = ok;
      w.last = ce;
      w.wx = 0;
      w.wy = 0;
      w.wz = 0;
      if (ok) begin
         for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) begin
               e = row[r][16*c +: 16];
               acc += longint'(e) * p[c];
            end
            acc = ((acc + 8192) >>> 14) + longint'(offs[r]);
            if (r == 0) w.wx = clamp32(acc);
            else if (r == 1) w.wy = clamp32(acc);
            else w.wz = clamp32(acc);
         end
      end
      pending = {pending, w};
   endfunction

   function void check_result(logic signed [31:0] wx, logic signed [31:0] wy,
                              logic signed [31:0] wz, logic kept, logic last);
      world_pt_type w;
      if (pending.size() == 0) begin
         $error("result with no point outstanding");
         errors++;
         return;
      end
      w = pending.pop_front();
      n_seen++;
      if (kept) n_kept++;
      if (wx !== w.wx) begin
         $error("world_x expected %0d got %0d", w.wx, wx);
         errors++;
      end
      if (wy !== w.wy) begin
         $error("world_y expected %0d got %0d", w.wy, wy);
         errors++;
      end
      if (wz !== w.wz) begin
         $error("world_z expected %0d got %0d", w.wz, wz);
         errors++;
      end
      if (kept !== w.kept) begin
         $error("kept expected %0d got %0d", w.kept, kept);
         errors++;
      end
      if (last !== w.last) begin
         $error("result_end expected %0d got %0d", w.last, last);
         errors++;
      end
   endfunction
endclass

module tb_lidar_point_fov_crop_transform;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 44;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm = 1'b0;
   int   cycles = 0;

   lfct_req_if req_ch ();
   lfct_rsp_if rsp_ch ();
   lfct_csr_if csr_ch ();

   crop_scoreboard sb;

   lidar_point_fov_crop_transform i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      req_ch.cloud_end = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // random back pressure on results, none in quiet stretches
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= calm || ($urandom_range(99) >= 7);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.world_x, rsp_ch.world_y, rsp_ch.world_z,
                         rsp_ch.kept, rsp_ch.result_end);
   end

   // write one register, then idle the channel
   task automatic write_csr(logic [lfct_pkg::IDX_W-1:0] idx, logic [63:0] d);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= d;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, d);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // send one point, idling first at random
   task automatic send_point(int x, int y, int z, logic ce);
      while (!calm && $urandom_range(99) < 7) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.point_x <= 24'(x);
      req_ch.point_y <= 24'(y);
      req_ch.point_z <= 24'(z);
      req_ch.cloud_end <= ce;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_point(24'(x), 24'(y), 24'(z), ce);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic int coord(int span);
      int v;
      v = int'($urandom_range(2 * span)) - span;
      return v;
   endfunction

   function automatic logic [47:0] pack_row(int a, int b, int c);
      logic [15:0] ea, eb, ec;
      ea = 16'(a);
      eb = 16'(b);
      ec = 16'(c);
      return {ec, eb, ea};
   endfunction

   // random point: mostly within a few meters, sometimes full scale
   task automatic random_points(int count);
      int x, y, z;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(9) < 7) begin
            x = coord(9000);
            y = coord(9000);
            z = coord(3000);
         end else begin
            x = int'($urandom);
            y = int'($urandom);
            z = int'($urandom);
         end
         send_point(x, y, z, $urandom_range(15) == 0);
      end
   endtask

   initial begin
      sb = new();
      sb.set_defaults();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and special points at reset settings
      send_point(0, 0, 0, 1'b0);
      send_point(8388607, 8388607, 8388607, 1'b1);
      send_point(-8388608, -8388608, -8388608, 1'b0);
      send_point(1000, -1000, 0, 1'b0);
      send_point(-1000, -1, 50, 1'b1);
      send_point(-1000, 0, -100, 1'b0);
      send_point(0, -2000, 0, 1'b0);
      send_point(0, 0, 500, 1'b0);
      send_point(0, 0, -500, 1'b0);
      send_point(7000, 0, 0, 1'b0);
      send_point(6999, 0, 0, 1'b1);
      send_point(3000, -3000, -300, 1'b0);
      drain();

      // every register: full-scale pose, huge range, open bounds
      write_csr(lfct_pkg::REG_ROW0, {16'h0, pack_row(32767, -32768, 100)});
      write_csr(lfct_pkg::REG_ROW1, {16'h0, pack_row(-32768, 32767, -32768)});
      write_csr(lfct_pkg::REG_ROW2, {16'h0, pack_row(0, 16384, -16384)});
      write_csr(lfct_pkg::REG_OFF_X, 64'h7fffffff);
      write_csr(lfct_pkg::REG_OFF_Y, 64'h80000000);
      write_csr(lfct_pkg::REG_OFF_Z, 64'd12345);
      write_csr(lfct_pkg::REG_RANGE, 64'hffffffffffff);
      write_csr(lfct_pkg::REG_FOV, {16'sd25736, -16'sd25736, 16'sd25736, -16'sd25736});
      write_csr(4'd12, 64'hdeadbeef);
      send_point(8388607, -8388608, 8388607, 1'b0);
      send_point(-8388608, 8388607, -8388608, 1'b1);
      send_point(0, 0, 0, 1'b0);
      send_point(-5, 3, 1, 1'b0);
      random_points(150);

      // sender holds off until every result is back
      drain();

      // crossed bounds reject everything
      write_csr(lfct_pkg::REG_FOV, {-16'sd100, 16'sd100, 16'sd0, 16'sd0});
      random_points(60);
      drain();

      // zero range limit, then random settings
      write_csr(lfct_pkg::REG_RANGE, 64'd0);
      write_csr(lfct_pkg::REG_FOV, {16'sd0, 16'sd0, 16'sd0, 16'sd0});
      random_points(30);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         for (int r = 0; r < 8; r++)
            write_csr(r[lfct_pkg::IDX_W-1:0], {$urandom, $urandom});
         write_csr(lfct_pkg::REG_RANGE, 64'($urandom_range(200000000)));
         write_csr(lfct_pkg::REG_FOV, {16'($urandom_range(25736)),
                                       -16'($urandom_range(25736)),
                                       16'($urandom_range(2000)),
                                       -16'($urandom_range(2000))});
         calm = (ph == 2);
         random_points(110);
         drain();
      end
      calm = 1'b0;

      // back to the reset pose
      write_csr(lfct_pkg::REG_ROW0, 64'd16384);
      write_csr(lfct_pkg::REG_ROW1, 64'd1073741824);
      write_csr(lfct_pkg::REG_ROW2, 64'd70368744177664);
      write_csr(lfct_pkg::REG_OFF_X, 64'd0);
      write_csr(lfct_pkg::REG_OFF_Y, 64'd0);
      write_csr(lfct_pkg::REG_OFF_Z, 64'd0);
      write_csr(lfct_pkg::REG_RANGE, 64'd49000000);
      write_csr(lfct_pkg::REG_FOV, 64'd170940185705495);
      random_points(60);
      drain();

      $display("Checked %0d results (%0d kept) across default, extreme and random poses,",
               sb.n_seen, sb.n_kept);
      $display("range limits and field-of-view windows, with stalls on both channels.");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

`default_nettype wire

FILE: lidar_point_fov_crop_transform.f
src/lfct_pkg.sv
src/lfct_if.sv
src/lfct_front.sv
src/lfct_sqrt_cell.sv
src/lfct_cordic_cell.sv
src/lidar_point_fov_crop_transform.sv
verif/tb_lidar_point_fov_crop_transform.sv
